// File: rtl/core/annexb_nal_unit_splitter_unit_assert.svh
// Assertion macros for the unit splitter.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_UNIT_ASSERT_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define ANNB_ASSERT(lbl, c, r, p, m) \
  lbl: assert property (@(posedge c) disable iff (!r) p) else $error(m);
`define ANNB_ASSERT_ALWAYS(lbl, c, p, m) \
  lbl: assert property (@(posedge c) p) else $error(m);
`else
`define ANNB_ASSERT(lbl, c, r, p, m)
`define ANNB_ASSERT_ALWAYS(lbl, c, p, m)
`endif

`endif

// File: rtl/core/annb_pkg.sv
`timescale 1ns / 1ps

package annb_pkg;

  localparam logic [7:0] START_BYTE   = 8'h01;
  localparam logic       CODEC_H264   = 1'b0;
  localparam logic       CODEC_H265   = 1'b1;

  localparam logic [5:0] H264_IDR     = 6'd5;
  localparam logic [5:0] H264_AUD     = 6'd9;
  localparam logic [5:0] H264_SLC_LO  = 6'd1;
  localparam logic [5:0] H264_SLC_HI  = 6'd5;
  localparam logic [5:0] H265_IRAP_LO = 6'd16;
  localparam logic [5:0] H265_IRAP_HI = 6'd21;
  localparam logic [5:0] H265_AUD     = 6'd35;
  localparam logic [5:0] H265_SLC_HI  = 6'd31;

  // zeros to commit, then an optional byte, then an optional end of unit
  typedef struct packed {
    logic [2:0] nzero;
    logic       has_byte;
    logic [7:0] data;
    logic       do_end;
  } cmd_t;

  typedef struct packed {
    logic [1:0] zero_run;
    logic       active;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/annb_front.sv
`timescale 1ns / 1ps

module annb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           byte_value,
  input  logic                 end_of_buffer,
  output logic                 push,
  output annb_pkg::cmd_t       cmd,
  output annb_pkg::front_stat_t stat
);

  logic [1:0] zero_run_r, zero_run_nxt;
  logic       inside_r, inside_nxt;

  always_comb begin
    cmd        = '0;
    zero_run_nxt = zero_run_r;
    inside_nxt = inside_r;
    if (byte_value == 8'h00) begin
      if (zero_run_r != 2'd3) begin
        zero_run_nxt = zero_run_r + 2'd1;
        if (end_of_buffer && inside_r) begin
          cmd.nzero  = {1'b0, zero_run_r} + 3'd1;
          cmd.do_end = 1'b1;
        end
      end else if (inside_r) begin
        cmd.nzero  = end_of_buffer ? 3'd4 : 3'd1;
        cmd.do_end = end_of_buffer;
      end
    end else if (byte_value == annb_pkg::START_BYTE && zero_run_r[1]) begin
      cmd.do_end   = inside_r;
      inside_nxt   = 1'b1;
      zero_run_nxt = 2'd0;
    end else begin
      if (inside_r) begin
        cmd.nzero    = {1'b0, zero_run_r};
        cmd.has_byte = 1'b1;
        cmd.data     = byte_value;
        cmd.do_end   = end_of_buffer;
      end
      zero_run_nxt = 2'd0;
    end
    if (end_of_buffer) begin
      zero_run_nxt = 2'd0;
      inside_nxt   = 1'b0;
    end
  end

  assign push = acc && (cmd.nzero != 3'd0 || cmd.has_byte || cmd.do_end);
  assign stat.zero_run = zero_run_r;
  assign stat.active   = inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= 2'd0;
      inside_r   <= 1'b0;
    end else if (acc) begin
      zero_run_r <= zero_run_nxt;
      inside_r   <= inside_nxt;
    end
  end

endmodule

// File: rtl/core/annb_queue.sv
`timescale 1ns / 1ps

module annb_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  annb_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output annb_pkg::cmd_t   head,
  output annb_pkg::q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  annb_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/annb_back.sv
`timescale 1ns / 1ps

module annb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           codec_select,
  input  logic           q_valid,
  input  annb_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_data_byte,
  output logic           out_first_of_unit,
  output logic           out_last_of_unit,
  output logic [5:0]     out_unit_type,
  output logic           out_is_random_access,
  output logic           out_is_delimiter,
  output logic           out_is_coded_slice,
  output logic           out_is_first_slice,
  output logic           out_end_of_run
);

  localparam logic [1:0] OP_ZERO = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  logic       work_valid_r;
  logic [2:0] zrem_r;
  logic       brem_r, erem_r;
  logic [7:0] wbyte_r;

  logic       held_valid_r, held_first_r, fsb_r;
  logic [7:0] held_byte_r;
  logic [1:0] hc_r;
  logic [5:0] type_r;

  logic       out_valid_r;
  logic [7:0] o_byte_r;
  logic       o_first_r, o_last_r, o_ra_r, o_dl_r, o_cs_r, o_fs_r, o_eor_r;
  logic [5:0] o_type_r;

  logic [1:0] op;
  logic [7:0] op_val;
  logic       op_last, fire, emits, load;
  logic       ra, dl, cs;

  always_comb begin
    if (zrem_r != 3'd0) begin
      op      = OP_ZERO;
      op_val  = 8'h00;
      op_last = (zrem_r == 3'd1) && !brem_r && !erem_r;
    end else if (brem_r) begin
      op      = OP_BYTE;
      op_val  = wbyte_r;
      op_last = !erem_r;
    end else begin
      op      = OP_END;
      op_val  = 8'h00;
      op_last = 1'b1;
    end
  end

  assign emits = held_valid_r;
  assign fire  = work_valid_r && (!emits || !out_valid_r || out_ready);
  assign load  = (!work_valid_r || (fire && op_last)) && q_valid;
  assign q_pop = load;

  always_comb begin
    if (codec_select == annb_pkg::CODEC_H265) begin
      ra = type_r inside {[annb_pkg::H265_IRAP_LO:annb_pkg::H265_IRAP_HI]};
      dl = (type_r == annb_pkg::H265_AUD);
      cs = (type_r <= annb_pkg::H265_SLC_HI);
    end else begin
      ra = (type_r == annb_pkg::H264_IDR);
      dl = (type_r == annb_pkg::H264_AUD);
      cs = type_r inside {[annb_pkg::H264_SLC_LO:annb_pkg::H264_SLC_HI]};
    end
  end

  // work register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      zrem_r       <= 3'd0;
      brem_r       <= 1'b0;
      erem_r       <= 1'b0;
    end else if (load) begin
      work_valid_r <= 1'b1;
      zrem_r       <= q_head.nzero;
      brem_r       <= q_head.has_byte;
      erem_r       <= q_head.do_end;
    end else if (fire && op_last) begin
      work_valid_r <= 1'b0;
    end else if (fire) begin
      case (op)
        OP_ZERO: zrem_r <= zrem_r - 3'd1;
        OP_BYTE: brem_r <= 1'b0;
        default: erem_r <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wbyte_r <= q_head.data;
    end
  end

  // held byte and header capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_first_r <= 1'b0;
      hc_r         <= 2'd0;
      type_r       <= 6'd0;
      fsb_r        <= 1'b0;
    end else if (fire) begin
      if (op == OP_END) begin
        held_valid_r <= 1'b0;
        held_first_r <= 1'b0;
        hc_r         <= 2'd0;
        type_r       <= 6'd0;
        fsb_r        <= 1'b0;
      end else begin
        held_valid_r <= 1'b1;
        held_first_r <= !held_valid_r;
        if (hc_r == 2'd0) begin
          type_r <= (codec_select == annb_pkg::CODEC_H265) ? op_val[6:1]
                                                           : {1'b0, op_val[4:0]};
        end
        if ((codec_select == annb_pkg::CODEC_H264 && hc_r == 2'd1) ||
            (codec_select == annb_pkg::CODEC_H265 && hc_r == 2'd2)) begin
          fsb_r <= op_val[7];
        end
        if (hc_r != 2'd3) begin
          hc_r <= hc_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && op != OP_END) begin
      held_byte_r <= op_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emits) begin
      o_byte_r  <= held_byte_r;
      o_first_r <= held_first_r;
      o_last_r  <= (op == OP_END);
      o_type_r  <= (op == OP_END) ? type_r : 6'd0;
      o_ra_r    <= (op == OP_END) && ra;
      o_dl_r    <= (op == OP_END) && dl;
      o_cs_r    <= (op == OP_END) && cs;
      o_fs_r    <= (op == OP_END) && cs && fsb_r;
      o_eor_r   <= op_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data_byte        = o_byte_r;
  assign out_first_of_unit    = o_first_r;
  assign out_last_of_unit     = o_last_r;
  assign out_unit_type        = o_type_r;
  assign out_is_random_access = o_ra_r;
  assign out_is_delimiter     = o_dl_r;
  assign out_is_coded_slice   = o_cs_r;
  assign out_is_first_slice   = o_fs_r;
  assign out_end_of_run       = o_eor_r;

endmodule

// File: rtl/core/annexb_nal_unit_splitter_unit.sv
`timescale 1ns / 1ps
// Annex-B splitter: takes one stream byte per cycle unless the
// QUEUE_DEPTH-entry queue is full, and delivers the unit payload bytes,
// start codes removed, one item per cycle through a single output register
// while out_ready allows. The front end scans for start codes and queues a
// command (pending zeros, byte, end of unit) per byte that yields one; the
// back end runs one command step per cycle unless the output stalls. A byte
// that releases a zero run, or ends a unit on end_of_buffer, yields up to
// five items. The first byte of each unit takes a back-end step without an
// item. codec_select is meant to be written only while the block is idle.
`include "annexb_nal_unit_splitter_unit_assert.svh"

module annexb_nal_unit_splitter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_first_of_unit,
  output logic       out_last_of_unit,
  output logic [5:0] out_unit_type,
  output logic       out_is_random_access,
  output logic       out_is_delimiter,
  output logic       out_is_coded_slice,
  output logic       out_is_first_slice,
  output logic       out_end_of_run
);

  logic codec_r;
  logic acc, push, pop;
  annb_pkg::cmd_t        cmd, head;
  annb_pkg::front_stat_t f_stat;
  annb_pkg::q_stat_t     q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= annb_pkg::CODEC_H264;
    end else if (cfg_wr_en) begin
      codec_r <= cfg_wr_data;
    end
  end

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;

  annb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .byte_value    (in_byte_value),
    .end_of_buffer (in_end_of_buffer),
    .push          (push),
    .cmd           (cmd),
    .stat          (f_stat)
  );

  annb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  annb_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .codec_select         (codec_r),
    .q_valid              (!q_stat.empty),
    .q_head               (head),
    .q_pop                (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data_byte        (out_data_byte),
    .out_first_of_unit    (out_first_of_unit),
    .out_last_of_unit     (out_last_of_unit),
    .out_unit_type        (out_unit_type),
    .out_is_random_access (out_is_random_access),
    .out_is_delimiter     (out_is_delimiter),
    .out_is_coded_slice   (out_is_coded_slice),
    .out_is_first_slice   (out_is_first_slice),
    .out_end_of_run       (out_end_of_run)
  );

  `ANNB_ASSERT(a_eob_clears_front, clk, rst_n, acc && in_end_of_buffer |=> f_stat.zero_run == 2'd0 && !f_stat.active, "front not cleared after end of buffer")
  `ANNB_ASSERT_ALWAYS(a_pop_not_empty, clk, pop |-> !q_stat.empty, "pop from empty queue")
  `ANNB_ASSERT(a_first_slice_on_last, clk, rst_n, out_valid && out_is_first_slice |-> out_last_of_unit && out_is_coded_slice, "first slice flag off a last slice item")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] value;
    logic       eob;
  } stream_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [5:0] utype;
    logic       ra;
    logic       dl;
    logic       cs;
    logic       fs;
    logic       eor;
  } unit_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte_value = 8'h00;
  logic       in_end_of_buffer = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_first_of_unit;
  logic       out_last_of_unit;
  logic [5:0] out_unit_type;
  logic       out_is_random_access;
  logic       out_is_delimiter;
  logic       out_is_coded_slice;
  logic       out_is_first_slice;
  logic       out_end_of_run;

  annexb_nal_unit_splitter_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte_value        (in_byte_value),
    .in_end_of_buffer     (in_end_of_buffer),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data_byte        (out_data_byte),
    .out_first_of_unit    (out_first_of_unit),
    .out_last_of_unit     (out_last_of_unit),
    .out_unit_type        (out_unit_type),
    .out_is_random_access (out_is_random_access),
    .out_is_delimiter     (out_is_delimiter),
    .out_is_coded_slice   (out_is_coded_slice),
    .out_is_first_slice   (out_is_first_slice),
    .out_end_of_run       (out_end_of_run)
  );

  always #10 clk = ~clk;

  stream_byte_t stream_q[$];
  unit_byte_t   unit_bytes_due[$];
  unit_byte_t   step_bytes[$];

  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_units = 0;
  int unsigned errors = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic        in_fire = 1'b0;

  // splitter state as the block should hold it
  logic       codec_now = annb_pkg::CODEC_H264;
  int         zeros_pending = 0;
  logic       in_unit = 1'b0;
  logic       held_ok = 1'b0;
  logic [7:0] held_val = 8'h00;
  logic       held_first = 1'b0;
  int         hdr_seen = 0;
  logic [5:0] nal_type = 6'd0;
  logic       slice_bit = 1'b0;

  logic [8:0] opening_bytes [26] = '{
    9'h0FF, 9'h000, 9'h000, 9'h000, 9'h001, 9'h065, 9'h080, 9'h000, 9'h000,
    9'h000, 9'h000, 9'h000, 9'h001, 9'h000, 9'h000, 9'h001, 9'h009, 9'h1FF,
    9'h000, 9'h000, 9'h001, 9'h041, 9'h000, 9'h001, 9'h000, 9'h100
  };

  task automatic emit_byte(logic [7:0] b, logic first, logic last);
    unit_byte_t r;
    r = '0;
    r.data = b;
    r.first = first;
    r.last = last;
    if (last) begin
      r.utype = nal_type;
      if (codec_now == annb_pkg::CODEC_H265) begin
        r.ra = (nal_type >= annb_pkg::H265_IRAP_LO) && (nal_type <= annb_pkg::H265_IRAP_HI);
        r.dl = (nal_type == annb_pkg::H265_AUD);
        r.cs = (nal_type <= annb_pkg::H265_SLC_HI);
      end else begin
        r.ra = (nal_type == annb_pkg::H264_IDR);
        r.dl = (nal_type == annb_pkg::H264_AUD);
        r.cs = (nal_type >= annb_pkg::H264_SLC_LO) && (nal_type <= annb_pkg::H264_SLC_HI);
      end
      r.fs = r.cs && slice_bit;
    end
    step_bytes.push_back(r);
  endtask

  task automatic commit_payload(logic [7:0] b);
    if (held_ok) emit_byte(held_val, held_first, 1'b0);
    held_first = !held_ok;
    held_ok = 1'b1;
    held_val = b;
    if (hdr_seen == 0) nal_type = (codec_now == annb_pkg::CODEC_H265) ? b[6:1] : {1'b0, b[4:0]};
    if ((codec_now == annb_pkg::CODEC_H264 && hdr_seen == 1) ||
        (codec_now == annb_pkg::CODEC_H265 && hdr_seen == 2)) slice_bit = b[7];
    if (hdr_seen < 3) hdr_seen++;
  endtask

  task automatic close_unit();
    if (held_ok) emit_byte(held_val, held_first, 1'b1);
    held_ok = 1'b0;
    held_first = 1'b0;
    hdr_seen = 0;
    nal_type = 6'd0;
    slice_bit = 1'b0;
  endtask

  task automatic split_byte(logic [7:0] b, logic eob);
    unit_byte_t r;
    step_bytes.delete();
    if (b == 8'h00) begin
      if (zeros_pending < 3) zeros_pending++;
      else if (in_unit) commit_payload(8'h00);
    end else if (b == annb_pkg::START_BYTE && zeros_pending >= 2) begin
      if (in_unit) close_unit();
      in_unit = 1'b1;
      zeros_pending = 0;
    end else begin
      if (in_unit) begin
        repeat (zeros_pending) commit_payload(8'h00);
        commit_payload(b);
      end
      zeros_pending = 0;
    end
    if (eob) begin
      if (in_unit) begin
        repeat (zeros_pending) commit_payload(8'h00);
        close_unit();
      end
      zeros_pending = 0;
      in_unit = 1'b0;
      held_val = 8'h00;
    end
    if (step_bytes.size() > 0) begin
      r = step_bytes.pop_back();
      r.eor = 1'b1;
      step_bytes.push_back(r);
    end
    foreach (step_bytes[i]) unit_bytes_due.push_back(step_bytes[i]);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // input driver
  always @(negedge clk) begin : drive
    stream_byte_t nx;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nx = stream_q.pop_front();
        in_valid <= 1'b1;
        in_byte_value <= nx.value;
        in_end_of_buffer <= nx.eob;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, long hold counted here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watch
    unit_byte_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (unit_bytes_due.size() == 0) begin
          $error("unexpected item: data_byte %0h", out_data_byte);
          errors++;
        end else begin
          want = unit_bytes_due.pop_front();
          check_field("data_byte", 32'(want.data), 32'(out_data_byte));
          check_field("first_of_unit", 32'(want.first), 32'(out_first_of_unit));
          check_field("last_of_unit", 32'(want.last), 32'(out_last_of_unit));
          check_field("unit_type", 32'(want.utype), 32'(out_unit_type));
          check_field("is_random_access", 32'(want.ra), 32'(out_is_random_access));
          check_field("is_delimiter", 32'(want.dl), 32'(out_is_delimiter));
          check_field("is_coded_slice", 32'(want.cs), 32'(out_is_coded_slice));
          check_field("is_first_slice", 32'(want.fs), 32'(out_is_first_slice));
          check_field("end_of_run", 32'(want.eor), 32'(out_end_of_run));
          n_results++;
          if (want.last) n_units++;
        end
      end
      if (in_valid && in_ready) begin
        split_byte(in_byte_value, in_end_of_buffer);
        items_accepted++;
      end
    end
  end

  task automatic push_item(logic [7:0] v, logic eob);
    stream_byte_t s;
    s.value = v;
    s.eob = eob;
    stream_q.push_back(s);
    items_queued++;
  endtask

  task automatic gen_stream(logic codec, int n);
    int unsigned stop_at;
    int          zeros;
    int          len;
    logic [5:0]  t;
    logic [7:0]  hb;
    logic        eob_end;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      if ($urandom_range(9) == 0) begin
        push_item(8'($urandom_range(255)), $urandom_range(19) == 0);
      end else begin
        zeros = ($urandom_range(9) == 0) ? 4 + $urandom_range(2) : 2 + $urandom_range(1);
        repeat (zeros) push_item(8'h00, 1'b0);
        eob_end = ($urandom_range(6) == 0);
        if ($urandom_range(9) == 0) begin
          push_item(annb_pkg::START_BYTE, eob_end);
        end else begin
          push_item(annb_pkg::START_BYTE, 1'b0);
          hb = 8'($urandom_range(255));
          if (codec == annb_pkg::CODEC_H265) begin
            case ($urandom_range(5))
              0: t = 6'($urandom_range(annb_pkg::H265_IRAP_HI, annb_pkg::H265_IRAP_LO));
              1: t = annb_pkg::H265_AUD;
              2: t = 6'($urandom_range(31));
              3: t = 6'($urandom_range(63, 32));
              4: t = annb_pkg::H265_SLC_HI;
              default: t = 6'd1;
            endcase
            hb[6:1] = t;
          end else begin
            case ($urandom_range(4))
              0: t = annb_pkg::H264_SLC_LO;
              1: t = annb_pkg::H264_IDR;
              2: t = annb_pkg::H264_AUD;
              3: t = 6'($urandom_range(31));
              default: t = 6'd0;
            endcase
            if ($urandom_range(3) != 0) hb[4:0] = t[4:0];
          end
          push_item(hb, 1'b0);
          len = $urandom_range(7);
          repeat (len) begin
            case ($urandom_range(9))
              0, 1: push_item(8'h00, 1'b0);
              2: begin
                repeat (1 + $urandom_range(4)) push_item(8'h00, 1'b0);
                push_item(8'($urandom_range(255, 2)), 1'b0);
              end
              3: begin
                push_item(8'h00, 1'b0);
                push_item(8'h00, 1'b0);
                push_item(8'h03, 1'b0);
              end
              default: push_item(8'($urandom_range(255)), 1'b0);
            endcase
          end
          if (eob_end) push_item(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)), 1'b1);
        end
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (items_accepted != items_queued || unit_bytes_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_codec(logic v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    codec_now = v;
  endtask

  task automatic run_phase(logic codec, int idle_in, int stall_out, bit long_hold, int n);
    write_codec(codec);
    @(posedge clk);
    send_idle_pct = idle_in;
    stall_pct = stall_out;
    if (long_hold) hold_asked++;
    gen_stream(codec, n / 2);
    wait_drained();
    @(posedge clk);
    gen_stream(codec, n - n / 2);
    wait_drained();
  endtask

  initial begin : main
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_codec(annb_pkg::CODEC_H264);
    @(posedge clk);
    foreach (opening_bytes[i]) push_item(opening_bytes[i][7:0], opening_bytes[i][8]);
    wait_drained();
    @(posedge clk);
    gen_stream(annb_pkg::CODEC_H264, 28);
    wait_drained();
    run_phase(annb_pkg::CODEC_H265, 77, 0, 1'b0, 34);
    run_phase(annb_pkg::CODEC_H265, 0, 77, 1'b1, 34);
    run_phase(annb_pkg::CODEC_H264, 12, 12, 1'b1, 34);
    run_phase(annb_pkg::CODEC_H265, 0, 0, 1'b0, 34);
    $display("%0d stream bytes in, %0d payload bytes checked over %0d closed units,",
             items_accepted, n_results, n_units);
    $display("both codecs, idle input, stalled output, long hold-offs and drained pauses");
    if (errors == 0) begin
      $display("annexb_nal_unit_splitter_unit regression: pass");
    end else begin
      $display("annexb_nal_unit_splitter_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timed out with %0d items outstanding", unit_bytes_due.size());
    $display("annexb_nal_unit_splitter_unit regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/annb_pkg.sv
rtl/core/annb_front.sv
rtl/core/annb_queue.sv
rtl/core/annb_back.sv
rtl/core/annexb_nal_unit_splitter_unit.sv
tb/tb_top.sv
